>>> hw/rtl/pnp_pkg.sv
// Shared constants and types for the polyline nearest-point block.
package pnp_pkg;

    localparam int ON_LINE_RESTRICT = 2;
    localparam int ON_LINE_LIM      = (ON_LINE_RESTRICT + 1) * (ON_LINE_RESTRICT + 1);

    typedef struct packed {
        logic busy;
        logic done;
    } scale_stat_t;

endpackage

>>> hw/rtl/pnp_scale.sv
// Bit-serial multiply-divide: q = round(num * ad / den), one bit of ad per cycle.
module pnp_scale
    import pnp_pkg::*;
#(
    parameter int COORD_BITS = 16
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [2*COORD_BITS+1:0]   num,
    input  logic [2*COORD_BITS+1:0]   den,
    input  logic [COORD_BITS:0]       ad,
    output logic [COORD_BITS:0]       q,
    output scale_stat_t               stat
);

    localparam int W  = 2 * COORD_BITS + 2;
    localparam int T  = W + 2;
    localparam int IW = $clog2(COORD_BITS + 1);

    logic [W-1:0]        acc_reg;
    logic [COORD_BITS:0] q_reg;
    logic [IW-1:0]       idx_reg;
    logic                busy_reg;
    logic                rnd_reg;
    logic                done_reg;

    logic [T-1:0]        t;
    logic [T-1:0]        den1;
    logic [T-1:0]        den2;
    logic [W-1:0]        acc_next;
    logic [1:0]          digit;
    logic                rnd_up;

    assign den1 = {2'b00, den};
    assign den2 = {1'b0, den, 1'b0};

    always_comb
    begin
        t = {1'b0, acc_reg, 1'b0} + (ad[idx_reg] ? {2'b00, num} : {T{1'b0}});
        if (t >= den2)
        begin
            acc_next = W'(t - den2);
            digit    = 2'd2;
        end
        else if (t >= den1)
        begin
            acc_next = W'(t - den1);
            digit    = 2'd1;
        end
        else
        begin
            acc_next = W'(t);
            digit    = 2'd0;
        end
    end

    // round half up on the final remainder
    assign rnd_up = ({1'b0, acc_reg, 1'b0} >= {2'b00, den});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            rnd_reg  <= 1'b0;
            done_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && rnd_reg;
            if (start && !busy_reg)
            begin
                acc_reg  <= '0;
                q_reg    <= '0;
                idx_reg  <= IW'(COORD_BITS);
                busy_reg <= 1'b1;
                rnd_reg  <= 1'b0;
            end
            else if (busy_reg && rnd_reg)
            begin
                q_reg    <= q_reg + (COORD_BITS+1)'(rnd_up);
                busy_reg <= 1'b0;
                rnd_reg  <= 1'b0;
            end
            else if (busy_reg)
            begin
                acc_reg <= acc_next;
                q_reg   <= (COORD_BITS+1)'({q_reg, 1'b0} + {{COORD_BITS{1'b0}}, digit});
                if (idx_reg == '0)
                    rnd_reg <= 1'b1;
                else
                    idx_reg <= idx_reg - 1'b1;
            end
        end
    end

    assign q         = q_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

>>> hw/rtl/polyline_nearest_point_core.sv
// Top level of the polyline nearest-point block.
//
// Vertices arrive on the vertex channel (vertex_valid / vertex_stall), each
// carrying the query point; first opens a polyline, last closes it. For each
// segment the clamped projection is found with one shared multiplier under a
// sequencer and a bit-serial multiply-divide unit, one quotient bit a cycle.
// A first vertex only seeds the best point and distance. Any other vertex
// skips the divider when the projection clamps, and runs two divider passes
// (x, then y) when it lands inside the segment.
// vertex_stall is high while a request is in work.
// On the last vertex one result goes out on the result channel
// (result_valid / result_stall) from an output register; the block takes the
// next request while it waits, and only holds the following last vertex
// until the receiver frees that register.
// Reset clears the state, the previous and best points and the output valid
// flag, and sets the limit register (written from cfg_wdata with cfg_we) to all ones.
module polyline_nearest_point_core
    import pnp_pkg::*;
#(
    parameter int COORD_BITS = 16
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [2*COORD_BITS+1:0]         cfg_wdata,
    input  logic                            vertex_valid,
    output logic                            vertex_stall,
    input  logic signed [COORD_BITS-1:0]    vertex_x,
    input  logic signed [COORD_BITS-1:0]    vertex_y,
    input  logic signed [COORD_BITS-1:0]    query_x,
    input  logic signed [COORD_BITS-1:0]    query_y,
    input  logic                            first,
    input  logic                            last,
    output logic                            result_valid,
    input  logic                            result_stall,
    output logic signed [COORD_BITS-1:0]    nearest_x,
    output logic signed [COORD_BITS-1:0]    nearest_y,
    output logic [2*COORD_BITS+1:0]         best_dist_sq,
    output logic                            on_line
);

    localparam int C  = COORD_BITS;
    localparam int DW = 2 * C + 2;

    typedef enum logic [3:0] {
        S_IDLE, S_DIFF, S_LEN0, S_LEN1, S_DOT0, S_DOT1, S_PICK,
        S_DIVX, S_DIVY, S_ERR, S_SQ0, S_SQ1, S_UPD, S_FIN
    } state_t;

    state_t                 state_reg;
    logic [DW-1:0]          limit_reg;

    logic signed [C-1:0]    vx_reg, vy_reg, qx_reg, qy_reg;
    logic                   last_reg;
    logic signed [C-1:0]    prev_x_reg, prev_y_reg;
    logic signed [C-1:0]    best_x_reg, best_y_reg;
    logic [DW-1:0]          best_sq_reg;

    logic signed [C:0]      dx_reg, dy_reg, ex_reg, ey_reg;
    logic signed [DW:0]     mac_reg;
    logic [DW-1:0]          len2_reg;
    logic signed [DW:0]     dot_reg;
    logic [DW-1:0]          sq_reg;
    logic signed [C-1:0]    nx_reg, ny_reg;

    logic signed [C-1:0]    out_x_reg, out_y_reg;
    logic [DW-1:0]          out_sq_reg;
    logic                   out_on_reg;
    logic                   out_valid_reg;

    logic signed [C:0]      mul_a, mul_b;
    logic signed [DW-1:0]   prod;
    logic signed [DW:0]     mac_sum;
    logic                   accept;
    logic                   out_load;
    logic                   clamp_a, clamp_b;
    logic                   div_start;
    logic [C:0]             div_ad;
    logic [C:0]             div_q;
    logic signed [C+1:0]    step_x, step_y;
    scale_stat_t            div_stat;

    assign accept       = vertex_valid && !vertex_stall;
    assign vertex_stall = (state_reg != S_IDLE);
    assign out_load     = (state_reg == S_FIN) && last_reg
                       && (!out_valid_reg || !result_stall);

    // shared multiplier operand select
    always_comb
    begin
        case (state_reg)
            S_LEN0:  begin mul_a = dx_reg; mul_b = dx_reg; end
            S_LEN1:  begin mul_a = dy_reg; mul_b = dy_reg; end
            S_DOT0:  begin mul_a = ex_reg; mul_b = dx_reg; end
            S_DOT1:  begin mul_a = ey_reg; mul_b = dy_reg; end
            S_SQ0:   begin mul_a = ex_reg; mul_b = ex_reg; end
            S_SQ1:   begin mul_a = ey_reg; mul_b = ey_reg; end
            default: begin mul_a = '0;     mul_b = '0;     end
        endcase
    end

    assign prod    = mul_a * mul_b;
    assign mac_sum = mac_reg + (DW+1)'(prod);

    assign clamp_a = (len2_reg == '0) || dot_reg[DW] || (dot_reg == '0);
    assign clamp_b = (dot_reg >= $signed({1'b0, len2_reg}));

    assign div_start = ((state_reg == S_PICK) && !clamp_a && !clamp_b)
                    || ((state_reg == S_DIVX) && div_stat.done);
    // hold |dx| through the x pass, |dy| through the y pass
    assign div_ad    = (state_reg != S_DIVY)
                     ? (dx_reg[C] ? (C+1)'(-dx_reg) : dx_reg)
                     : (dy_reg[C] ? (C+1)'(-dy_reg) : dy_reg);

    assign step_x = dx_reg[C] ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q});
    assign step_y = dy_reg[C] ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q});

    pnp_scale #(
        .COORD_BITS (COORD_BITS)
    ) u_scale (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (DW'(dot_reg)),
        .den   (len2_reg),
        .ad    (div_ad),
        .q     (div_q),
        .stat  (div_stat)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            limit_reg     <= '1;
            prev_x_reg    <= '0;
            prev_y_reg    <= '0;
            best_x_reg    <= '0;
            best_y_reg    <= '0;
            best_sq_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                limit_reg <= cfg_wdata;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !result_stall)
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        vx_reg   <= vertex_x;
                        vy_reg   <= vertex_y;
                        qx_reg   <= query_x;
                        qy_reg   <= query_y;
                        last_reg <= last;
                        if (first)
                        begin
                            best_x_reg  <= vertex_x;
                            best_y_reg  <= vertex_y;
                            best_sq_reg <= limit_reg;
                            state_reg   <= S_FIN;
                        end
                        else
                            state_reg <= S_DIFF;
                    end
                end
                S_DIFF:
                begin
                    dx_reg    <= (C+1)'(vx_reg) - (C+1)'(prev_x_reg);
                    dy_reg    <= (C+1)'(vy_reg) - (C+1)'(prev_y_reg);
                    ex_reg    <= (C+1)'(qx_reg) - (C+1)'(prev_x_reg);
                    ey_reg    <= (C+1)'(qy_reg) - (C+1)'(prev_y_reg);
                    state_reg <= S_LEN0;
                end
                S_LEN0:
                begin
                    mac_reg   <= (DW+1)'(prod);
                    state_reg <= S_LEN1;
                end
                S_LEN1:
                begin
                    len2_reg  <= DW'(mac_sum);
                    state_reg <= S_DOT0;
                end
                S_DOT0:
                begin
                    mac_reg   <= (DW+1)'(prod);
                    state_reg <= S_DOT1;
                end
                S_DOT1:
                begin
                    dot_reg   <= mac_sum;
                    state_reg <= S_PICK;
                end
                S_PICK:
                begin
                    if (clamp_a)
                    begin
                        nx_reg    <= prev_x_reg;
                        ny_reg    <= prev_y_reg;
                        state_reg <= S_ERR;
                    end
                    else if (clamp_b)
                    begin
                        nx_reg    <= vx_reg;
                        ny_reg    <= vy_reg;
                        state_reg <= S_ERR;
                    end
                    else
                        state_reg <= S_DIVX;
                end
                S_DIVX:
                begin
                    if (div_stat.done)
                    begin
                        nx_reg    <= C'((C+2)'(prev_x_reg) + step_x);
                        state_reg <= S_DIVY;
                    end
                end
                S_DIVY:
                begin
                    if (div_stat.done)
                    begin
                        ny_reg    <= C'((C+2)'(prev_y_reg) + step_y);
                        state_reg <= S_ERR;
                    end
                end
                S_ERR:
                begin
                    ex_reg    <= (C+1)'(qx_reg) - (C+1)'(nx_reg);
                    ey_reg    <= (C+1)'(qy_reg) - (C+1)'(ny_reg);
                    state_reg <= S_SQ0;
                end
                S_SQ0:
                begin
                    mac_reg   <= (DW+1)'(prod);
                    state_reg <= S_SQ1;
                end
                S_SQ1:
                begin
                    sq_reg    <= DW'(mac_sum);
                    state_reg <= S_UPD;
                end
                S_UPD:
                begin
                    if (sq_reg < best_sq_reg)
                    begin
                        best_sq_reg <= sq_reg;
                        best_x_reg  <= nx_reg;
                        best_y_reg  <= ny_reg;
                    end
                    state_reg <= S_FIN;
                end
                S_FIN:
                begin
                    prev_x_reg <= vx_reg;
                    prev_y_reg <= vy_reg;
                    if (!last_reg)
                        state_reg <= S_IDLE;
                    else if (out_load)
                    begin
                        // load the output register; hold here while it is full
                        out_x_reg  <= best_x_reg;
                        out_y_reg  <= best_y_reg;
                        out_sq_reg <= best_sq_reg;
                        out_on_reg <= (best_sq_reg < DW'(ON_LINE_LIM));
                        state_reg  <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign result_valid = out_valid_reg;
    assign nearest_x    = out_x_reg;
    assign nearest_y    = out_y_reg;
    assign best_dist_sq = out_sq_reg;
    assign on_line      = out_on_reg;

    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> (state_reg == S_DIVX || state_reg == S_DIVY))
        else $error("divider finished outside a divide step");

    a_on_line_match: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (on_line == (best_dist_sq < DW'(ON_LINE_LIM))))
        else $error("on_line disagrees with best_dist_sq");

    a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(state_reg == S_FIN && last_reg))
        else $error("result raised outside the finish step");

    a_div_idle_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> !div_stat.busy)
        else $error("request taken while divider busy");

endmodule
